// ----- rtl/sandpile_toppling_engine_core_defines.svh -----
// Assertion helpers for the sandpile engine datapath, the one file that includes them.
`ifndef SANDPILE_TOPPLING_ENGINE_CORE_DEFINES_SVH
`define SANDPILE_TOPPLING_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the module clock and disabled in reset.
`define STE_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sandpile engine assertion failed");

// Next-cycle implication.
`define STE_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sandpile engine assertion failed");

`endif

// ----- rtl/ste_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ste_pkg;

  localparam logic [1:0] OP_SOURCE = 2'd0;
  localparam logic [1:0] OP_SWEEP  = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_GRID_HEIGHT = 2'd1;

  localparam logic [1:0] NB_UP    = 2'd0;
  localparam logic [1:0] NB_DOWN  = 2'd1;
  localparam logic [1:0] NB_LEFT  = 2'd2;
  localparam logic [1:0] NB_RIGHT = 2'd3;

  localparam int STABLE_MAX  = 3;
  localparam int TOPPLE_LOSS = 4;
  localparam int POS_CMP_W   = 13;
  localparam int CFG_W       = 9;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic [23:0] amount;
  } in_t;

  typedef struct packed {
    logic [23:0] cell_height;
    logic [2:0]  color_class;
    logic [16:0] active_count;
  } out_t;

  typedef struct packed {
    logic clear_step;
    logic accept;
    logic sweep_start;
    logic src_read;
    logic src_write;
    logic rd_read;
    logic rd_capture;
    logic list_read;
    logic list_capture;
    logic cell_read;
    logic cell_write;
    logic nb_clr;
    logic nb_inc;
    logic nb_read;
    logic nb_write;
    logic sweep_end;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic       clear_last;
    logic [1:0] op;
    logic       in_grid;
    logic       list_done;
    logic       cell_stable;
    logic       nb_valid;
    logic       nb_last;
    logic       out_busy;
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/ste_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ste_ctrl (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire ste_pkg::sts_t sts_i,
  output ste_pkg::cmd_t    cmd_o
);
  import ste_pkg::*;

  typedef enum logic [15:0] {
    ST_CLEAR    = 16'h0001,
    ST_IDLE     = 16'h0002,
    ST_DISPATCH = 16'h0004,
    ST_SRC_RD   = 16'h0008,
    ST_SRC_WR   = 16'h0010,
    ST_RD_RD    = 16'h0020,
    ST_RD_DATA  = 16'h0040,
    ST_SW_LIST  = 16'h0080,
    ST_SW_LWAIT = 16'h0100,
    ST_SW_CRD   = 16'h0200,
    ST_SW_CWR   = 16'h0400,
    ST_SW_NSEL  = 16'h0800,
    ST_SW_NRD   = 16'h1000,
    ST_SW_NWR   = 16'h2000,
    ST_SW_END   = 16'h4000,
    ST_FIN      = 16'h8000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (sts_i.op)
          OP_SOURCE: state_d = sts_i.in_grid ? ST_SRC_RD : ST_FIN;
          OP_SWEEP: begin
            cmd_o.sweep_start = 1'b1;
            state_d = ST_SW_LIST;
          end
          OP_READ: state_d = sts_i.in_grid ? ST_RD_RD : ST_FIN;
          default: state_d = ST_FIN;
        endcase
      end
      ST_SRC_RD: begin
        cmd_o.src_read = 1'b1;
        state_d = ST_SRC_WR;
      end
      ST_SRC_WR: begin
        cmd_o.src_write = 1'b1;
        state_d = ST_FIN;
      end
      ST_RD_RD: begin
        cmd_o.rd_read = 1'b1;
        state_d = ST_RD_DATA;
      end
      ST_RD_DATA: begin
        cmd_o.rd_capture = 1'b1;
        state_d = ST_FIN;
      end
      ST_SW_LIST: begin
        if (sts_i.list_done) begin
          state_d = ST_SW_END;
        end else begin
          cmd_o.list_read = 1'b1;
          state_d = ST_SW_LWAIT;
        end
      end
      ST_SW_LWAIT: begin
        cmd_o.list_capture = 1'b1;
        state_d = ST_SW_CRD;
      end
      ST_SW_CRD: begin
        cmd_o.cell_read = 1'b1;
        state_d = ST_SW_CWR;
      end
      ST_SW_CWR: begin
        cmd_o.cell_write = 1'b1;
        cmd_o.nb_clr = 1'b1;
        state_d = sts_i.cell_stable ? ST_SW_LIST : ST_SW_NSEL;
      end
      ST_SW_NSEL: begin
        if (sts_i.nb_valid) begin
          state_d = ST_SW_NRD;
        end else if (sts_i.nb_last) begin
          state_d = ST_SW_LIST;
        end else begin
          cmd_o.nb_inc = 1'b1;
        end
      end
      ST_SW_NRD: begin
        cmd_o.nb_read = 1'b1;
        state_d = ST_SW_NWR;
      end
      ST_SW_NWR: begin
        cmd_o.nb_write = 1'b1;
        if (sts_i.nb_last) begin
          state_d = ST_SW_LIST;
        end else begin
          cmd_o.nb_inc = 1'b1;
          state_d = ST_SW_NSEL;
        end
      end
      ST_SW_END: begin
        cmd_o.sweep_end = 1'b1;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/ste_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "sandpile_toppling_engine_core_defines.svh"

module ste_datapath #(
  parameter int GRID_COLS  = 256,
  parameter int GRID_ROWS  = 256,
  parameter int GRAIN_BITS = 24
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire ste_pkg::in_t    in_data_i,
  input  wire logic            cfg_valid_i,
  input  wire logic [1:0]      cfg_index_i,
  input  wire logic [8:0]      cfg_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output ste_pkg::out_t        out_data_o,
  input  wire ste_pkg::cmd_t   cmd_i,
  output ste_pkg::sts_t        sts_o
);
  import ste_pkg::*;

  localparam int CELLS = GRID_COLS * GRID_ROWS;
  localparam int XW    = $clog2(GRID_COLS);
  localparam int YW    = $clog2(GRID_ROWS);
  localparam int CW    = $clog2(CELLS);
  localparam int LW    = $clog2(CELLS + 1);
  localparam int HW    = GRAIN_BITS;
  localparam int PW    = POS_CMP_W;

  localparam logic [HW-1:0] HMAX = {HW{1'b1}};
  localparam logic [HW-1:0] HSTB = HW'(STABLE_MAX);
  localparam logic [LW-1:0] LCAP = LW'(CELLS);

  // Configuration registers and the clamped grid extent.
  logic [CFG_W-1:0] cfg_w_q, cfg_h_q;
  logic [PW-1:0]    wu, hu;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= CFG_W'(256);
      cfg_h_q <= CFG_W'(256);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_GRID_WIDTH)  cfg_w_q <= cfg_data_i;
      if (cfg_index_i == CFG_GRID_HEIGHT) cfg_h_q <= cfg_data_i;
    end
  end

  always_comb begin
    if (cfg_w_q == '0) wu = PW'(1);
    else if (PW'(cfg_w_q) > PW'(GRID_COLS)) wu = PW'(GRID_COLS);
    else wu = PW'(cfg_w_q);
    if (cfg_h_q == '0) hu = PW'(1);
    else if (PW'(cfg_h_q) > PW'(GRID_ROWS)) hu = PW'(GRID_ROWS);
    else hu = PW'(cfg_h_q);
  end

  // Item registers.
  logic [1:0]    op_q;
  logic          inside_q;
  logic [XW-1:0] x_q;
  logic [YW-1:0] y_q;
  logic [HW-1:0] amt_q;
  logic [PW-1:0] xe, ye;
  logic          amt_big;

  assign xe      = PW'(in_data_i.pos_x);
  assign ye      = PW'(in_data_i.pos_y);
  assign amt_big = 32'(in_data_i.amount) > 32'(HMAX);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q     <= in_data_i.operation;
      inside_q <= (xe < wu) && (ye < hu);
      x_q      <= xe[XW-1:0];
      y_q      <= ye[YW-1:0];
      amt_q    <= amt_big ? HMAX : HW'(in_data_i.amount);
    end
  end

  // Sweep registers.
  logic [XW-1:0] cx_q, nx;
  logic [YW-1:0] cy_q, ny;
  logic [1:0]    nb_q;
  logic          nb_valid;
  logic [LW-1:0] idx_q, cur_len_q, nxt_len_q;
  logic          sel_q;
  logic [CW-1:0] clr_q;

  always_comb begin
    nx = cx_q;
    ny = cy_q;
    case (nb_q)
      NB_UP: begin
        ny = cy_q - 1'b1;
        nb_valid = (cy_q != '0);
      end
      NB_DOWN: begin
        ny = cy_q + 1'b1;
        nb_valid = (PW'(cy_q) + PW'(1)) < hu;
      end
      NB_LEFT: begin
        nx = cx_q - 1'b1;
        nb_valid = (cx_q != '0);
      end
      default: begin
        nx = cx_q + 1'b1;
        nb_valid = (PW'(cx_q) + PW'(1)) < wu;
      end
    endcase
  end

  logic [31:0]   item_lin, cell_lin, nb_lin;
  logic [CW-1:0] item_addr, cell_addr, nb_addr;

  assign item_lin  = 32'(y_q) * 32'(GRID_COLS) + 32'(x_q);
  assign cell_lin  = 32'(cy_q) * 32'(GRID_COLS) + 32'(cx_q);
  assign nb_lin    = 32'(ny) * 32'(GRID_COLS) + 32'(nx);
  assign item_addr = item_lin[CW-1:0];
  assign cell_addr = cell_lin[CW-1:0];
  assign nb_addr   = nb_lin[CW-1:0];

  // Height store: each word holds the queued mark above the grain count.
  logic [HW:0]   pile_mem [CELLS];
  logic [HW:0]   prd_q;
  logic [CW-1:0] pr_addr, pw_addr;
  logic [HW:0]   pw_data;
  logic          pw_en;
  logic          pr_en;
  logic          mark;
  logic [HW-1:0] h, h4, hn;
  logic          src_app, keep, nw_app, stable;

  assign mark   = prd_q[HW];
  assign h      = prd_q[HW-1:0];
  assign h4     = h - HW'(TOPPLE_LOSS);
  assign hn     = (h == HMAX) ? h : h + 1'b1;
  assign stable = (h <= HSTB);
  assign src_app = (amt_q > HSTB) && !mark && (cur_len_q < LCAP);
  assign keep    = (h4 > HSTB) && (nxt_len_q < LCAP);
  assign nw_app  = (hn > HSTB) && !mark && (nxt_len_q < LCAP);
  assign pr_en   = cmd_i.src_read || cmd_i.rd_read || cmd_i.cell_read || cmd_i.nb_read;

  always_comb begin
    if (cmd_i.cell_read) pr_addr = cell_addr;
    else if (cmd_i.nb_read) pr_addr = nb_addr;
    else pr_addr = item_addr;

    pw_en   = 1'b1;
    pw_addr = clr_q;
    pw_data = '0;
    if (cmd_i.src_write) begin
      pw_addr = item_addr;
      pw_data = {mark | src_app, amt_q};
    end else if (cmd_i.cell_write) begin
      pw_addr = cell_addr;
      pw_data = stable ? {1'b0, h} : {keep, h4};
    end else if (cmd_i.nb_write) begin
      pw_addr = nb_addr;
      pw_data = {mark | nw_app, hn};
    end else if (!cmd_i.clear_step) begin
      pw_en = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pw_en) pile_mem[pw_addr] <= pw_data;
    if (pr_en) prd_q <= pile_mem[pr_addr];
  end

  // Two list memories; sel_q picks the one holding the current list.
  logic [XW+YW-1:0] la_mem [CELLS];
  logic [XW+YW-1:0] lb_mem [CELLS];
  logic [XW+YW-1:0] la_q, lb_q, app_data, lrd;
  logic [LW-1:0]    app_len;
  logic             app_en, app_b;

  always_comb begin
    app_en   = 1'b0;
    app_data = {ny, nx};
    app_len  = nxt_len_q;
    app_b    = !sel_q;
    if (cmd_i.src_write) begin
      app_en   = src_app;
      app_data = {y_q, x_q};
      app_len  = cur_len_q;
      app_b    = sel_q;
    end else if (cmd_i.cell_write) begin
      app_en   = !stable && keep;
      app_data = {cy_q, cx_q};
    end else if (cmd_i.nb_write) begin
      app_en   = nw_app;
    end
  end

  always_ff @(posedge clk_i) begin
    if (app_en && !app_b) la_mem[app_len[CW-1:0]] <= app_data;
    if (cmd_i.list_read) la_q <= la_mem[idx_q[CW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (app_en && app_b) lb_mem[app_len[CW-1:0]] <= app_data;
    if (cmd_i.list_read) lb_q <= lb_mem[idx_q[CW-1:0]];
  end

  assign lrd = sel_q ? lb_q : la_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.list_capture) {cy_q, cx_q} <= lrd;
    if (cmd_i.nb_clr) nb_q <= NB_UP;
    else if (cmd_i.nb_inc) nb_q <= nb_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      cur_len_q <= '0;
      nxt_len_q <= '0;
      sel_q     <= 1'b0;
      clr_q     <= '0;
    end else begin
      if (cmd_i.clear_step) clr_q <= clr_q + 1'b1;
      if (cmd_i.sweep_start) begin
        idx_q     <= '0;
        nxt_len_q <= '0;
      end else begin
        if (cmd_i.list_capture) idx_q <= idx_q + 1'b1;
        if (app_en && !cmd_i.src_write) nxt_len_q <= nxt_len_q + 1'b1;
      end
      if (app_en && cmd_i.src_write) cur_len_q <= cur_len_q + 1'b1;
      if (cmd_i.sweep_end) begin
        cur_len_q <= nxt_len_q;
        sel_q     <= !sel_q;
      end
    end
  end

  // Result.
  logic [HW-1:0] rd_h_q;
  logic          out_valid_q;
  out_t          out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) rd_h_q <= '0;
    else if (cmd_i.rd_capture) rd_h_q <= h;
    if (cmd_i.out_load) begin
      out_q.cell_height  <= (32'(rd_h_q) > 32'h00FF_FFFF) ? 24'hFF_FFFF : 24'(rd_h_q);
      out_q.color_class  <= (rd_h_q > HSTB) ? 3'd4 : 3'(rd_h_q);
      out_q.active_count <= (32'(cur_len_q) > 32'h0001_FFFF) ? 17'h1_FFFF
                                                            : 17'(cur_len_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    sts_o.clear_last  = (clr_q == CW'(CELLS - 1));
    sts_o.op          = op_q;
    sts_o.in_grid     = inside_q;
    sts_o.list_done   = (idx_q >= cur_len_q);
    sts_o.cell_stable = stable;
    sts_o.nb_valid    = nb_valid;
    sts_o.nb_last     = (nb_q == NB_RIGHT);
    sts_o.out_busy    = out_valid_q && out_stall_i;
  end

  `STE_ASSERT_IMPL(a_len_bound, 1'b1, (cur_len_q <= LCAP) && (nxt_len_q <= LCAP))
  `STE_ASSERT_IMPL(a_app_room, app_en, app_len < LCAP)
  `STE_ASSERT_NEXT(a_swap_len, cmd_i.sweep_end, cur_len_q == $past(nxt_len_q))

endmodule

`default_nettype wire

// ----- rtl/sandpile_toppling_engine_core.sv -----
// Steps: a source reads its cell and writes it back, a read fetches its cell, and a sweep
// reads and rewrites each listed cell and, for each cell that topples, each in-grid neighbour.
// Throughput: one item at a time; the next is taken once the result is registered,
// and a result that waits at the output holds the engine.
// Reset: asynchronous, active low; afterwards the height store is swept clear, cell by cell,
// and no item is taken until the sweep is done.
`timescale 1ns / 1ps
`default_nettype none

module sandpile_toppling_engine_core #(
  parameter int GRID_COLS  = 256,
  parameter int GRID_ROWS  = 256,
  parameter int GRAIN_BITS = 24
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire ste_pkg::in_t   in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output ste_pkg::out_t       out_data_o,
  input  wire logic           cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire logic [1:0]     cfg_index_i,
  input  wire logic [8:0]     cfg_data_i
);
  import ste_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  ste_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ste_datapath #(
    .GRID_COLS  (GRID_COLS),
    .GRID_ROWS  (GRID_ROWS),
    .GRAIN_BITS (GRAIN_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import ste_pkg::*;

  localparam int unsigned CELLS = 65536;
  localparam logic [23:0] GRAIN_TOP = 24'hFFFFFF;

  typedef struct {
    in_t  item;
    bit   typed;
    out_t want;
  } dir_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  in_t        in_data_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  out_t       out_data_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i = CFG_GRID_WIDTH;
  logic [8:0] cfg_data_i = '0;

  // Model of the grid, kept in step with every accepted beat.
  logic [23:0] pile [CELLS];
  bit          marked [CELLS];
  logic [15:0] now_list [CELLS];
  logic [15:0] nxt_list [CELLS];
  int unsigned now_len;
  int unsigned nxt_len;
  logic [8:0]  cols_reg;
  logic [8:0]  rows_reg;

  out_t     pending_results [$];
  dir_row_t dir_rows [$];
  int       mismatches;
  int       sent;
  bit       calm = 1'b0;
  bit       hold_req = 1'b0;
  bit       hold_done = 1'b0;
  int       hold_left = 0;

  sandpile_toppling_engine_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #40ms;
    $display("FAIL");
    $finish;
  end

  function automatic int unsigned dim_in_use(logic [8:0] v);
    if (v == 0) return 1;
    if (v > 256) return 256;
    return v;
  endfunction

  function automatic void add_grain(int unsigned c);
    if (pile[c] != GRAIN_TOP) pile[c] = pile[c] + 1;
    if (pile[c] > STABLE_MAX && !marked[c] && nxt_len < CELLS) begin
      marked[c] = 1'b1;
      nxt_list[nxt_len] = c[15:0];
      nxt_len++;
    end
  endfunction

  function automatic void topple_pass();
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned x;
    int unsigned y;
    w = dim_in_use(cols_reg);
    h = dim_in_use(rows_reg);
    nxt_len = 0;
    for (int unsigned i = 0; i < now_len; i++) begin
      c = now_list[i];
      x = c % 256;
      y = c / 256;
      if (pile[c] <= STABLE_MAX) begin
        marked[c] = 1'b0;
        continue;
      end
      pile[c] = pile[c] - TOPPLE_LOSS;
      if (pile[c] > STABLE_MAX && nxt_len < CELLS) begin
        nxt_list[nxt_len] = c[15:0];
        nxt_len++;
      end else begin
        marked[c] = 1'b0;
      end
      if (y > 0) add_grain(c - 256);
      if (y + 1 < h) add_grain(c + 256);
      if (x > 0) add_grain(c - 1);
      if (x + 1 < w) add_grain(c + 1);
    end
    for (int unsigned i = 0; i < nxt_len; i++) now_list[i] = nxt_list[i];
    now_len = nxt_len;
  endfunction

  function automatic out_t grid_after(in_t it);
    out_t        r;
    int unsigned c;
    bit          ins;
    r = '0;
    ins = it.pos_x < dim_in_use(cols_reg) && it.pos_y < dim_in_use(rows_reg);
    c = {it.pos_y, it.pos_x};
    case (it.operation)
      OP_SOURCE: begin
        if (ins) begin
          pile[c] = it.amount;
          if (it.amount > STABLE_MAX && !marked[c] && now_len < CELLS) begin
            marked[c] = 1'b1;
            now_list[now_len] = c[15:0];
            now_len++;
          end
        end
      end
      OP_SWEEP: topple_pass();
      OP_READ: begin
        if (ins) begin
          r.cell_height = pile[c];
          r.color_class = (pile[c] > STABLE_MAX) ? 3'd4 : pile[c][2:0];
        end
      end
      default: ;
    endcase
    r.active_count = now_len[16:0];
    return r;
  endfunction

  function automatic in_t make_beat(logic [1:0] op, int x, int y, int amt);
    in_t it;
    it.operation = op;
    it.pos_x = x[7:0];
    it.pos_y = y[7:0];
    it.amount = amt[23:0];
    return it;
  endfunction

  task automatic add_row(logic [1:0] op, int x, int y, int amt, bit typed,
                         int hgt = 0, int cls = 0, int cnt = 0);
    dir_row_t row;
    row.item = make_beat(op, x, y, amt);
    row.typed = typed;
    row.want.cell_height = hgt[23:0];
    row.want.color_class = cls[2:0];
    row.want.active_count = cnt[16:0];
    dir_rows.push_back(row);
  endtask

  // Offers one beat; valid stays high across back-to-back beats.
  task automatic send_beat(in_t it, bit typed, out_t want);
    out_t predicted;
    while (!calm && $urandom_range(0, 99) < 10) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    predicted = grid_after(it);
    pending_results.push_back(typed ? want : predicted);
    sent++;
    calm <= (sent >= 300 && sent < 400);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [8:0] val);
    in_valid_i <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (20) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_GRID_WIDTH) cols_reg = val;
    else rows_reg = val;
  endtask

  function automatic in_t random_beat(bit tame);
    int unsigned pick;
    int unsigned amt;
    int unsigned x;
    int unsigned y;
    logic [1:0]  op;
    pick = $urandom_range(0, 99);
    if (pick < 38) op = OP_SOURCE;
    else if (pick < 63) op = OP_SWEEP;
    else if (pick < 95) op = OP_READ;
    else op = 2'd3;
    if ($urandom_range(0, 99) < 15) begin
      x = $urandom_range(0, 255);
      y = $urandom_range(0, 255);
    end else begin
      x = $urandom_range(0, dim_in_use(cols_reg) - 1);
      y = $urandom_range(0, dim_in_use(rows_reg) - 1);
    end
    pick = $urandom_range(0, 99);
    if (pick < 15) amt = $urandom_range(0, 3);
    else if (pick < 88 || tame) amt = $urandom_range(4, 20);
    else amt = $urandom_range(0, 24'hFFFFFF);
    return make_beat(op, x, y, amt);
  endfunction

  // Receiver: random stalls, one long hold-off, and a calm stretch.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(0, 99) < 10);
    end
  end

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", out_data_o);
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.cell_height !== want.cell_height ||
            out_data_o.color_class !== want.color_class ||
            out_data_o.active_count !== want.active_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: height %0d/%0d class %0d/%0d count %0d/%0d (exp/act)",
                     want.cell_height, out_data_o.cell_height,
                     want.color_class, out_data_o.color_class,
                     want.active_count, out_data_o.active_count);
        end
      end
    end
  end

  initial begin
    int widths [8] = '{511, 0, 1, 511, 8, 16, 3, 5};
    int heights [8] = '{511, 0, 511, 1, 8, 16, 13, 7};
    int counts [8] = '{30, 40, 60, 60, 120, 120, 80, 100};
    for (int unsigned i = 0; i < CELLS; i++) begin
      pile[i] = '0;
      marked[i] = 1'b0;
    end
    now_len = 0;
    nxt_len = 0;
    cols_reg = 9'd256;
    rows_reg = 9'd256;
    mismatches = 0;
    sent = 0;

    // Reset contents, small sources, a saturated source, unknown operation.
    add_row(OP_READ, 0, 0, 0, 1, 0, 0, 0);
    add_row(OP_READ, 255, 255, 0, 1, 0, 0, 0);
    add_row(OP_SOURCE, 0, 0, 3, 1, 0, 0, 0);
    add_row(OP_READ, 0, 0, 0, 1, 3, 3, 0);
    add_row(OP_SOURCE, 255, 255, 24'hFFFFFF, 1, 0, 0, 1);
    add_row(OP_READ, 255, 255, 0, 1, 24'hFFFFFF, 4, 1);
    add_row(OP_SOURCE, 255, 255, 5, 1, 0, 0, 1);
    add_row(OP_SOURCE, 0, 0, 4, 1, 0, 0, 2);
    add_row(2'd3, 255, 255, 24'hFFFFFF, 1, 0, 0, 2);
    add_row(OP_SOURCE, 10, 10, 9, 1, 0, 0, 3);
    add_row(OP_SWEEP, 0, 0, 0, 0);
    add_row(OP_READ, 0, 1, 0, 0);
    // A listed cell made stable again drops off the list at the next sweep.
    add_row(OP_SOURCE, 10, 10, 2, 0);
    add_row(OP_SWEEP, 0, 0, 0, 0);
    add_row(OP_READ, 10, 10, 0, 0);
    add_row(OP_READ, 255, 254, 0, 0);
    add_row(OP_SOURCE, 128, 200, 0, 0);
    add_row(OP_READ, 128, 200, 0, 0);
    add_row(OP_SOURCE, 0, 255, 7, 0);
    add_row(OP_SWEEP, 0, 0, 0, 0);
    add_row(OP_READ, 1, 255, 0, 0);
    add_row(OP_READ, 0, 254, 0, 0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) send_beat(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

    for (int p = 0; p < 8; p++) begin
      write_reg(CFG_GRID_WIDTH, widths[p]);
      write_reg(CFG_GRID_HEIGHT, heights[p]);
      if (p == 4) hold_req <= 1'b1;
      for (int n = 0; n < counts[p]; n++) send_beat(random_beat(p == 0), 1'b0, '0);
    end

    in_valid_i <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
